/* src/double_ended_queue_engine_unit_defines.svh */
// Assertion macros shared by the deque engine RTL.
// No dependencies; included by modules that carry assertions.
`ifndef DOUBLE_ENDED_QUEUE_ENGINE_UNIT_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, checked on clk, off during rst.
`define DEQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off during rst.
`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/deq_pkg.sv */
// Shared types, codes and sizes for the deque engine.
// No dependencies; imported by every module of the block except deq_ram.
`timescale 1ns / 1ps

package deq_pkg;

  localparam int DEPTH      = 64;
  localparam int ELEM_WIDTH = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = 7;
  localparam int CMD_W      = 3;
  localparam int STAT_W     = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ_AT    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd5;
  localparam logic [CMD_W-1:0] CMD_ERASE      = 3'd6;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd7;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd3;

  // read address select
  localparam logic [1:0] RA_POS  = 2'd0;
  localparam logic [1:0] RA_BACK = 2'd1;
  localparam logic [1:0] RA_HEAD = 2'd2;
  localparam logic [1:0] RA_SRC  = 2'd3;

  // write address select
  localparam logic [1:0] WA_COUNT  = 2'd0;
  localparam logic [1:0] WA_HEADM1 = 2'd1;
  localparam logic [1:0] WA_POS    = 2'd2;
  localparam logic [1:0] WA_IDX    = 2'd3;

  // head / count update
  localparam logic [1:0] UPD_HOLD = 2'd0;
  localparam logic [1:0] UPD_INC  = 2'd1;
  localparam logic [1:0] UPD_DEC  = 2'd2;
  localparam logic [1:0] UPD_ZERO = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]      cmd;
    logic [CNT_W-1:0]      position;
    logic [ELEM_WIDTH-1:0] value;
  } deq_in_t;

  typedef struct packed {
    logic [ELEM_WIDTH-1:0] data_out;
    logic [CNT_W-1:0]      occupancy;
    logic [STAT_W-1:0]     status;
  } deq_out_t;

  typedef struct packed {
    logic              ld_in;
    logic              ram_rd;
    logic [1:0]        rd_sel;
    logic              ram_wr;
    logic [1:0]        wr_sel;
    logic              wr_from_ram;
    logic [1:0]        head_op;
    logic [1:0]        cnt_op;
    logic              loop_ld;
    logic              idx_step;
    logic              cap_data;
    logic              set_stat;
    logic [STAT_W-1:0] stat_code;
    logic              res_ld;
  } ctrl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             full;
    logic             empty;
    logic             pos_ge_cnt;
    logic             pos_gt_cnt;
    logic             pos_lt_half;
    logic             loop_done;
  } stat_t;

endpackage

/* src/deq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/deq_dpath.sv */
// Deque datapath: ring store, head and count, shift index, result register.
// Depends on deq_pkg and deq_ram.
`timescale 1ns / 1ps

module deq_dpath (
  input  logic             clk,
  input  logic             rst,
  input  deq_pkg::deq_in_t in_data,
  input  deq_pkg::ctrl_t   ctl,
  output deq_pkg::stat_t   st,
  output deq_pkg::deq_out_t res
);
  import deq_pkg::*;

  logic [CMD_W-1:0]      cmd_r;
  logic [CNT_W-1:0]      pos_r;
  logic [ELEM_WIDTH-1:0] val_r;
  logic [ADDR_W-1:0]     head;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      idx;
  logic [CNT_W-1:0]      limit;
  logic                  step_up;
  logic [ELEM_WIDTH-1:0] data_r;
  logic [STAT_W-1:0]     stat_r;

  logic [CNT_W-1:0]      src_idx;
  logic [ADDR_W-1:0]     rd_addr;
  logic [ADDR_W-1:0]     wr_addr;
  logic [ELEM_WIDTH-1:0] wr_data;
  logic [ELEM_WIDTH-1:0] rd_data;

  function automatic logic [ADDR_W-1:0] slot_of(logic [ADDR_W-1:0] h, logic [CNT_W-1:0] i);
    slot_of = h + i[ADDR_W-1:0];
  endfunction

  assign src_idx = step_up ? CNT_W'(idx + CNT_W'(1)) : CNT_W'(idx - CNT_W'(1));

  always_comb begin
    case (ctl.rd_sel)
      RA_POS:  rd_addr = slot_of(head, pos_r);
      RA_BACK: rd_addr = slot_of(head, CNT_W'(count - CNT_W'(1)));
      RA_HEAD: rd_addr = head;
      RA_SRC:  rd_addr = slot_of(head, src_idx);
      default: rd_addr = head;
    endcase
  end

  always_comb begin
    case (ctl.wr_sel)
      WA_COUNT:  wr_addr = slot_of(head, count);
      WA_HEADM1: wr_addr = ADDR_W'(head - ADDR_W'(1));
      WA_POS:    wr_addr = slot_of(head, pos_r);
      WA_IDX:    wr_addr = slot_of(head, idx);
      default:   wr_addr = head;
    endcase
  end

  assign wr_data = ctl.wr_from_ram ? rd_data : val_r;

  deq_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.ram_wr),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (ctl.ram_rd),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      case (ctl.head_op)
        UPD_INC:  head <= ADDR_W'(head + ADDR_W'(1));
        UPD_DEC:  head <= ADDR_W'(head - ADDR_W'(1));
        UPD_ZERO: head <= '0;
        default:  head <= head;
      endcase
      case (ctl.cnt_op)
        UPD_INC:  count <= CNT_W'(count + CNT_W'(1));
        UPD_DEC:  count <= CNT_W'(count - CNT_W'(1));
        UPD_ZERO: count <= '0;
        default:  count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_in) begin
      cmd_r  <= in_data.cmd;
      pos_r  <= in_data.position;
      val_r  <= in_data.value;
      data_r <= '0;
      stat_r <= STAT_OK;
    end else begin
      if (ctl.cap_data) begin
        data_r <= rd_data;
      end
      if (ctl.set_stat) begin
        stat_r <= ctl.stat_code;
      end
    end
    // set up the shift walk: on insert the front side moves toward the head, back side away; erase the reverse
    if (ctl.loop_ld) begin
      if (cmd_r == CMD_INSERT) begin
        if (st.pos_lt_half) begin
          idx     <= '0;
          limit   <= pos_r;
          step_up <= 1'b1;
        end else begin
          idx     <= count;
          limit   <= pos_r;
          step_up <= 1'b0;
        end
      end else begin
        if (st.pos_lt_half) begin
          idx     <= pos_r;
          limit   <= '0;
          step_up <= 1'b0;
        end else begin
          idx     <= pos_r;
          limit   <= CNT_W'(count - CNT_W'(1));
          step_up <= 1'b1;
        end
      end
    end else if (ctl.idx_step) begin
      idx <= src_idx;
    end
    if (ctl.res_ld) begin
      res.data_out  <= data_r;
      res.occupancy <= count;
      res.status    <= stat_r;
    end
  end

  assign st.cmd         = cmd_r;
  assign st.full        = (count == CNT_W'(DEPTH));
  assign st.empty       = (count == '0);
  assign st.pos_ge_cnt  = (pos_r >= count);
  assign st.pos_gt_cnt  = (pos_r > count);
  assign st.pos_lt_half = (pos_r < (count >> 1));
  assign st.loop_done   = (idx == limit);

endmodule

/* src/deq_ctrl.sv */
// Deque controller: sequences each command over the datapath.
// Depends on deq_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "double_ended_queue_engine_unit_defines.svh"

module deq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  deq_pkg::stat_t st,
  output deq_pkg::ctrl_t ctl
);
  import deq_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECODE  = 3'd1;
  localparam logic [2:0] S_RD_WAIT = 3'd2;
  localparam logic [2:0] S_LOOP    = 3'd3;
  localparam logic [2:0] S_MV_WR   = 3'd4;
  localparam logic [2:0] S_FINISH  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.ld_in  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_FINISH;
        case (st.cmd)
          CMD_PUSH_BACK: begin
            if (st.full) begin
              ctl.set_stat  = 1'b1;
              ctl.stat_code = STAT_FULL;
            end else begin
              ctl.ram_wr = 1'b1;
              ctl.wr_sel = WA_COUNT;
              ctl.cnt_op = UPD_INC;
            end
          end
          CMD_PUSH_FRONT: begin
            if (st.full) begin
              ctl.set_stat  = 1'b1;
              ctl.stat_code = STAT_FULL;
            end else begin
              ctl.ram_wr  = 1'b1;
              ctl.wr_sel  = WA_HEADM1;
              ctl.head_op = UPD_DEC;
              ctl.cnt_op  = UPD_INC;
            end
          end
          CMD_POP_BACK: begin
            if (st.empty) begin
              ctl.set_stat  = 1'b1;
              ctl.stat_code = STAT_EMPTY;
            end else begin
              ctl.ram_rd = 1'b1;
              ctl.rd_sel = RA_BACK;
              ctl.cnt_op = UPD_DEC;
              state_next = S_RD_WAIT;
            end
          end
          CMD_POP_FRONT: begin
            if (st.empty) begin
              ctl.set_stat  = 1'b1;
              ctl.stat_code = STAT_EMPTY;
            end else begin
              ctl.ram_rd  = 1'b1;
              ctl.rd_sel  = RA_HEAD;
              ctl.head_op = UPD_INC;
              ctl.cnt_op  = UPD_DEC;
              state_next  = S_RD_WAIT;
            end
          end
          CMD_READ_AT: begin
            if (st.pos_ge_cnt) begin
              ctl.set_stat  = 1'b1;
              ctl.stat_code = STAT_RANGE;
            end else begin
              ctl.ram_rd = 1'b1;
              ctl.rd_sel = RA_POS;
              state_next = S_RD_WAIT;
            end
          end
          CMD_INSERT: begin
            if (st.pos_gt_cnt) begin
              ctl.set_stat  = 1'b1;
              ctl.stat_code = STAT_RANGE;
            end else if (st.full) begin
              ctl.set_stat  = 1'b1;
              ctl.stat_code = STAT_FULL;
            end else begin
              ctl.loop_ld = 1'b1;
              // open a slot ahead of the head before the front side moves
              if (st.pos_lt_half) begin
                ctl.head_op = UPD_DEC;
              end
              state_next = S_LOOP;
            end
          end
          CMD_ERASE: begin
            if (st.pos_ge_cnt) begin
              ctl.set_stat  = 1'b1;
              ctl.stat_code = STAT_RANGE;
            end else begin
              ctl.ram_rd  = 1'b1;
              ctl.rd_sel  = RA_POS;
              ctl.loop_ld = 1'b1;
              state_next  = S_RD_WAIT;
            end
          end
          default: begin
            ctl.head_op = UPD_ZERO;
            ctl.cnt_op  = UPD_ZERO;
          end
        endcase
      end
      S_RD_WAIT: begin
        ctl.cap_data = 1'b1;
        state_next   = (st.cmd == CMD_ERASE) ? S_LOOP : S_FINISH;
      end
      S_LOOP: begin
        if (st.loop_done) begin
          state_next = S_FINISH;
          if (st.cmd == CMD_INSERT) begin
            ctl.ram_wr = 1'b1;
            ctl.wr_sel = WA_POS;
            ctl.cnt_op = UPD_INC;
          end else begin
            ctl.cnt_op = UPD_DEC;
            if (st.pos_lt_half) begin
              ctl.head_op = UPD_INC;
            end
          end
        end else begin
          ctl.ram_rd = 1'b1;
          ctl.rd_sel = RA_SRC;
          state_next = S_MV_WR;
        end
      end
      S_MV_WR: begin
        ctl.ram_wr      = 1'b1;
        ctl.wr_sel      = WA_IDX;
        ctl.wr_from_ram = 1'b1;
        ctl.idx_step    = 1'b1;
        state_next      = S_LOOP;
      end
      S_FINISH: begin
        // hold until the result register is free
        if (!out_valid || out_ready) begin
          ctl.res_ld = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.res_ld) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `DEQ_ASSERT_NEXT(a_accept_decodes, in_valid && in_ready, state == S_DECODE, "accept did not decode")
  `DEQ_ASSERT_NEXT(a_finish_shows, ctl.res_ld, out_valid && state == S_IDLE, "result not shown")
  `DEQ_ASSERT_SAME(a_move_after_read, state == S_MV_WR, $past(ctl.ram_rd), "move write without read")

endmodule

/* src/double_ended_queue_engine_unit.sv */
// Deque engine top level: controller plus datapath around a ring RAM.
// Depends on deq_pkg, deq_ctrl and deq_dpath.
//
// Input channel in_valid/in_ready/in_data carries one command item
// (cmd, position, value); output channel out_valid/out_ready/out_data
// returns exactly one result item (data_out, occupancy, status) per command.
// One command is in work at a time; in_ready is high only when the engine
// is idle, and a finished result sits in an output register so the next
// command can be taken while that result waits.
// Push, clear and any error go from decode straight to finish; pop and read
// first pass a wait state for the registered RAM read. Insert walks the shift
// loop over k elements and erase reads the erased element first, then walks
// the loop, where k is the number of elements moved, at most about half the
// occupancy. Each move is one RAM read then one RAM write through the
// single-port-pair ring store.
// Reset clears head, count and the output valid; stored elements are not
// cleared, and only occupied entries are ever read.
// When the receiver stalls the result holds in the output register and a
// following command completes its work, then waits until that result is taken.
`timescale 1ns / 1ps

module double_ended_queue_engine_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  deq_pkg::deq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output deq_pkg::deq_out_t out_data
);
  import deq_pkg::*;

  ctrl_t ctl;
  stat_t st;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .ctl       (ctl)
  );

  deq_dpath u_dpath (
    .clk     (clk),
    .rst     (rst),
    .in_data (in_data),
    .ctl     (ctl),
    .st      (st),
    .res     (out_data)
  );

endmodule

/* verif/tb_double_ended_queue_engine_unit.sv */
// Testbench for the deque engine: drives command items, predicts each result
// with a behavioral deque and checks every result item. Depends on deq_pkg and the engine top.
`timescale 1ns / 1ps

class deq_scoreboard;
  logic [deq_pkg::ELEM_WIDTH-1:0] ring [deq_pkg::DEPTH];
  int unsigned head;
  int unsigned count;
  deq_pkg::deq_out_t pending[$];
  int errors;

  function new();
    head = 0;
    count = 0;
    errors = 0;
    foreach (ring[i]) ring[i] = '0;
  endfunction

  function int unsigned slot(int unsigned i);
    return (head + i) % deq_pkg::DEPTH;
  endfunction

  // apply one accepted command and queue its result
  function void note_command(deq_pkg::deq_in_t it);
    deq_pkg::deq_out_t r;
    int unsigned p;
    p = it.position;
    r.data_out = '0;
    r.status = deq_pkg::STAT_OK;
    case (it.cmd)
      deq_pkg::CMD_PUSH_BACK: begin
        if (count >= deq_pkg::DEPTH) r.status = deq_pkg::STAT_FULL;
        else begin
          ring[slot(count)] = it.value;
          count++;
        end
      end
      deq_pkg::CMD_PUSH_FRONT: begin
        if (count >= deq_pkg::DEPTH) r.status = deq_pkg::STAT_FULL;
        else begin
          head = (head + deq_pkg::DEPTH - 1) % deq_pkg::DEPTH;
          ring[head] = it.value;
          count++;
        end
      end
      deq_pkg::CMD_POP_BACK: begin
        if (count == 0) r.status = deq_pkg::STAT_EMPTY;
        else begin
          r.data_out = ring[slot(count - 1)];
          count--;
        end
      end
      deq_pkg::CMD_POP_FRONT: begin
        if (count == 0) r.status = deq_pkg::STAT_EMPTY;
        else begin
          r.data_out = ring[head];
          head = (head + 1) % deq_pkg::DEPTH;
          count--;
        end
      end
      deq_pkg::CMD_READ_AT: begin
        if (p >= count) r.status = deq_pkg::STAT_RANGE;
        else r.data_out = ring[slot(p)];
      end
      deq_pkg::CMD_INSERT: begin
        if (p > count) r.status = deq_pkg::STAT_RANGE;
        else if (count >= deq_pkg::DEPTH) r.status = deq_pkg::STAT_FULL;
        else begin
          if (p < count / 2) begin
            head = (head + deq_pkg::DEPTH - 1) % deq_pkg::DEPTH;
            for (int unsigned i = 0; i < p; i++) ring[slot(i)] = ring[slot(i + 1)];
          end else begin
            for (int unsigned i = count; i > p; i--) ring[slot(i)] = ring[slot(i - 1)];
          end
          ring[slot(p)] = it.value;
          count++;
        end
      end
      deq_pkg::CMD_ERASE: begin
        if (p >= count) r.status = deq_pkg::STAT_RANGE;
        else begin
          r.data_out = ring[slot(p)];
          if (p < count / 2) begin
            for (int unsigned i = p; i > 0; i--) ring[slot(i)] = ring[slot(i - 1)];
            head = (head + 1) % deq_pkg::DEPTH;
          end else begin
            for (int unsigned i = p; i + 1 < count; i++) ring[slot(i)] = ring[slot(i + 1)];
          end
          count--;
        end
      end
      default: begin
        head = 0;
        count = 0;
      end
    endcase
    r.occupancy = count[deq_pkg::CNT_W-1:0];
    pending.push_back(r);
  endfunction

  function void check_result(deq_pkg::deq_out_t got);
    deq_pkg::deq_out_t exp;
    if (pending.size() == 0) begin
      $error("result item with nothing expected: %h", got);
      errors++;
      return;
    end
    exp = pending.pop_front();
    if (got.data_out !== exp.data_out) begin
      $error("data_out expected %h actual %h", exp.data_out, got.data_out);
      errors++;
    end
    if (got.occupancy !== exp.occupancy) begin
      $error("occupancy expected %0d actual %0d", exp.occupancy, got.occupancy);
      errors++;
    end
    if (got.status !== exp.status) begin
      $error("status expected %0d actual %0d", exp.status, got.status);
      errors++;
    end
  endfunction
endclass

module tb_double_ended_queue_engine_unit;
  import deq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  deq_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  deq_out_t out_data;

  deq_scoreboard sb = new();
  bit calm = 1'b0;
  int cycles = 0;

  double_ended_queue_engine_unit dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
    if (!rst && in_valid && in_ready) sb.note_command(in_data);
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  // receiver: random stall bursts, none in the calm tail
  initial begin
    int n;
    @(negedge clk);
    while (1) begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 16);
        repeat (n) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // leave valid high after the accept; the next send or drain decides
  task automatic send(logic [CMD_W-1:0] c, int unsigned p, logic [ELEM_WIDTH-1:0] v);
    int n;
    deq_in_t it;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      n = $urandom_range(1, 16);
      repeat (n) @(negedge clk);
    end
    it.cmd = c;
    it.position = p[CNT_W-1:0];
    it.value = v;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  // position biased toward the valid range, with some out-of-range noise
  function automatic int unsigned pick_pos();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 127);
    return $urandom_range(0, sb.count);
  endfunction

  initial begin
    int unsigned c;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty errors, extremes, fill to full, full errors
    send(CMD_POP_BACK, 0, '0);
    send(CMD_POP_FRONT, 0, '0);
    send(CMD_READ_AT, 0, '0);
    send(CMD_ERASE, 0, '0);
    send(CMD_INSERT, 1, 32'h1);
    send(CMD_INSERT, 0, 32'hFFFF_FFFF);
    send(CMD_PUSH_FRONT, 0, 32'h0);
    send(CMD_PUSH_BACK, 127, 32'hA5A5_5A5A);
    send(CMD_READ_AT, 2, '0);
    send(CMD_READ_AT, 3, '0);
    send(CMD_INSERT, 3, 32'h5A5A_A5A5);
    send(CMD_INSERT, 1, 32'h1234_5678);
    send(CMD_ERASE, 1, '0);
    send(CMD_ERASE, 2, '0);
    send(CMD_POP_BACK, 0, '0);
    send(CMD_POP_FRONT, 0, '0);
    send(CMD_CLEAR, 0, '0);
    while (sb.count < DEPTH) send(CMD_PUSH_BACK, 0, $urandom);
    send(CMD_PUSH_BACK, 0, '1);
    send(CMD_PUSH_FRONT, 0, '1);
    send(CMD_INSERT, 64, '1);
    send(CMD_INSERT, 65, '1);
    send(CMD_READ_AT, 63, '0);
    send(CMD_READ_AT, 64, '0);
    send(CMD_ERASE, 0, '0);
    send(CMD_ERASE, 62, '0);
    send(CMD_ERASE, 31, '0);
    // hold off until every result is back
    drain();

    for (int k = 0; k < 700; k++) begin
      if (k == 600) calm = 1'b1;
      if (k == 300) drain();
      c = $urandom_range(0, 99);
      if (c < 18) send(CMD_PUSH_BACK, $urandom_range(0, 127), $urandom);
      else if (c < 34) send(CMD_PUSH_FRONT, $urandom_range(0, 127), $urandom);
      else if (c < 44) send(CMD_POP_BACK, $urandom_range(0, 127), $urandom);
      else if (c < 54) send(CMD_POP_FRONT, $urandom_range(0, 127), $urandom);
      else if (c < 68) send(CMD_READ_AT, pick_pos(), $urandom);
      else if (c < 84) send(CMD_INSERT, pick_pos(), $urandom);
      else if (c < 98) send(CMD_ERASE, pick_pos(), $urandom);
      else send(CMD_CLEAR, $urandom_range(0, 127), $urandom);
    end

    drain();
    repeat (200) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
